// ----- design/assert_macros.svh -----
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock outside reset
`define GMA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked every clock with no reset qualifier
`define GMA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/gma_pkg.sv -----
// package for the group mean accumulator: sizes, codes and shared types
package gma_pkg;
  localparam int GROUPS = 256;
  localparam int COLS = 16;
  localparam int GW = 8;
  localparam int CW = 4;
  localparam int AW = GW + CW;
  localparam int SUM_W = 48;
  localparam int CNT_W = 24;
  localparam int DEN_W = CNT_W + 9;
  localparam int NUM_W = SUM_W + 8;
  localparam int Q_W = NUM_W;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ACC = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             neg;
  } div_req_t;
endpackage

// ----- design/gma_div.sv -----
// serial restoring divider producing the saturated signed mean
module gma_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  gma_pkg::div_req_t          req,
  output logic                       done,
  output logic [31:0]                mean
);
  localparam int N = gma_pkg::NUM_W;
  localparam int D = gma_pkg::DEN_W;
  logic [N-1:0] q_r, q_nxt;
  logic [D:0] rem_r, rem_nxt;
  logic [D-1:0] den_r;
  logic neg_r;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_nxt;
  logic [D:0] sh;
  logic [N-1:0] sat;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh = '0;
    if (start) begin
      q_nxt = req.num;
      rem_nxt = '0;
      cnt_nxt = 6'(N - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      sh = {rem_r[D-1:0], q_r[N-1]};
      q_nxt = {q_r[N-2:0], 1'b0};
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = sh;
      end
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      cnt_nxt = cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done <= done_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (start) begin
      den_r <= req.den;
      neg_r <= req.neg;
    end
  end

  always_comb begin
    if (neg_r) begin
      sat = (q_r > N'(64'h8000_0000)) ? N'(64'h8000_0000) : q_r;
      mean = 32'(~sat + N'(1));
    end else begin
      sat = (q_r > N'(64'h7FFF_FFFF)) ? N'(64'h7FFF_FFFF) : q_r;
      mean = sat[31:0];
    end
  end
endmodule

// ----- design/group_mean_accumulator.sv -----
// Group mean accumulator. Accumulate transactions (action 1) add a Q16.16 value into a
// per-group, per-column 48-bit saturating sum held in a 4096-entry memory and, on column 0,
// bump the group's row count in a 256-entry memory; they stream back to back while the
// block runs with no result pending, forwarding registers covering the read-modify-write
// of the same entry. A read transaction (action 2) reads both memories, then runs a serial
// divider of sum*256 / (count*256 + shrinkage), one quotient bit per cycle; no further
// transaction is accepted until its result is taken. Clear (action 0) and reset sweep all
// entries to zero, one entry per cycle, taking no transaction. Config writes are taken any time.
module group_mean_accumulator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // action[1:0], group[10:2], column[14:11], value[46:15], zero pad to 48
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // mean[31:0], group_count[55:32], highest_group[64:56], index_error[65], pad to 72
  output logic [71:0] out_tdata
);
  localparam int AW = gma_pkg::AW;
  localparam int GW = gma_pkg::GW;
  localparam int SW = gma_pkg::SUM_W;
  localparam int CW = gma_pkg::CNT_W;

  localparam logic [2:0] ST_CLR = 3'd0;
  localparam logic [2:0] ST_RUN = 3'd1;
  localparam logic [2:0] ST_RD = 3'd2;
  localparam logic [2:0] ST_DIV = 3'd3;
  localparam logic [2:0] ST_OUT = 3'd4;

  logic [SW-1:0] sum_mem [0:(1<<AW)-1];
  logic [CW-1:0] cnt_mem [0:(1<<GW)-1];

  logic [2:0] st_r, st_nxt;
  logic [AW-1:0] clr_r;
  logic [15:0] shrink_r;
  logic [8:0] hi_r;
  logic err_r;
  logic [71:0] out_r;
  logic outv_r;

  logic [1:0] act;
  logic [8:0] grp;
  logic [3:0] col;
  logic [31:0] val;
  logic acc_ok, in_fire, gvalid;
  logic [GW-1:0] g0;
  logic [AW-1:0] addr;

  // stage 1 of accumulate
  logic s1_r, s1_c0_r;
  logic [AW-1:0] s1_a_r;
  logic [31:0] s1_v_r;
  logic [SW-1:0] sum_q, cur_sum, new_sum;
  logic [CW-1:0] cnt_q, cur_cnt;
  logic [SW+1:0] wide;
  // last written values for forwarding
  logic [AW-1:0] lw_a_r;
  logic [SW-1:0] lw_s_r;
  logic lw_v_r;
  logic [GW-1:0] lc_g_r;
  logic [CW-1:0] lc_c_r;
  logic lc_v_r;

  // read bookkeeping
  logic rd_valid_r, rd_col_ok_r;
  logic div_start, div_done;
  logic [31:0] div_mean;
  gma_pkg::div_req_t req;
  logic [CW-1:0] rd_cnt_r;
  logic [SW-1:0] mag;

  assign act = in_tdata[1:0];
  assign grp = in_tdata[10:2];
  assign col = in_tdata[14:11];
  assign val = in_tdata[46:15];
  assign gvalid = (grp != 9'd0) && (grp <= 9'(gma_pkg::GROUPS));
  assign g0 = GW'(grp - 9'd1);
  assign addr = {g0, col};
  assign in_tready = (st_r == ST_RUN) && !outv_r;
  assign in_fire = in_tvalid && in_tready;
  assign acc_ok = in_fire && act == gma_pkg::ACT_ACC && gvalid;
  assign out_tvalid = outv_r;
  assign out_tdata = out_r;

  always_comb begin
    cur_sum = (lw_v_r && lw_a_r == s1_a_r) ? lw_s_r : sum_q;
    cur_cnt = (lc_v_r && lc_g_r == s1_a_r[AW-1:4]) ? lc_c_r : cnt_q;
    wide = {{2{cur_sum[SW-1]}}, cur_sum} + {{(SW-30){s1_v_r[31]}}, s1_v_r};
    if ($signed(wide) > $signed({2'b00, gma_pkg::SUM_MAX}))
      new_sum = gma_pkg::SUM_MAX;
    else if ($signed(wide) < $signed({2'b11, gma_pkg::SUM_MIN}))
      new_sum = gma_pkg::SUM_MIN;
    else
      new_sum = wide[SW-1:0];
  end

  always_ff @(posedge clk) begin
    sum_q <= sum_mem[addr];
    cnt_q <= cnt_mem[g0];
    if (st_r == ST_CLR) begin
      sum_mem[clr_r] <= '0;
      cnt_mem[clr_r[GW-1:0]] <= '0;
    end else if (s1_r) begin
      sum_mem[s1_a_r] <= new_sum;
      if (s1_c0_r && cur_cnt != gma_pkg::CNT_MAX)
        cnt_mem[s1_a_r[AW-1:4]] <= cur_cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    s1_a_r <= addr;
    s1_v_r <= val;
    s1_c0_r <= (col == 4'd0);
    if (s1_r) begin
      lw_a_r <= s1_a_r;
      lw_s_r <= new_sum;
      if (s1_c0_r) begin
        lc_g_r <= s1_a_r[AW-1:4];
        lc_c_r <= (cur_cnt != gma_pkg::CNT_MAX) ? cur_cnt + CW'(1) : cur_cnt;
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLR: if (clr_r == {AW{1'b1}}) st_nxt = ST_RUN;
      ST_RUN: begin
        if (in_fire && act == gma_pkg::ACT_CLEAR) st_nxt = ST_CLR;
        else if (in_fire && act == gma_pkg::ACT_READ) st_nxt = ST_RD;
      end
      ST_RD: st_nxt = ST_DIV;
      ST_DIV: if (div_done) st_nxt = ST_OUT;
      ST_OUT: st_nxt = ST_RUN;
      default: st_nxt = ST_CLR;
    endcase
  end

  assign div_start = (st_r == ST_RD);
  always_comb begin
    mag = cur_sum[SW-1] ? (~cur_sum + SW'(1)) : cur_sum;
    req.num = {mag, 8'd0};
    req.den = {cur_cnt, 8'd0} + {{(gma_pkg::DEN_W-16){1'b0}}, shrink_r};
    req.neg = cur_sum[SW-1];
  end

  gma_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .req(req),
    .done(div_done), .mean(div_mean)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLR;
      clr_r <= '0;
      shrink_r <= '0;
      hi_r <= '0;
      err_r <= 1'b0;
      outv_r <= 1'b0;
      s1_r <= 1'b0;
      lw_v_r <= 1'b0;
      lc_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) shrink_r <= cfg_wdata;
      clr_r <= (st_r == ST_CLR) ? clr_r + AW'(1) : '0;
      s1_r <= acc_ok && 5'(col) < 5'(gma_pkg::COLS);
      if (st_r == ST_CLR) begin
        lw_v_r <= 1'b0;
        lc_v_r <= 1'b0;
      end else if (s1_r) begin
        lw_v_r <= 1'b1;
        if (s1_c0_r) lc_v_r <= 1'b1;
      end
      if (in_fire && act == gma_pkg::ACT_CLEAR) begin
        hi_r <= '0;
        err_r <= 1'b0;
      end else if (in_fire && act == gma_pkg::ACT_ACC) begin
        if (!gvalid) err_r <= 1'b1;
        else if (5'(col) < 5'(gma_pkg::COLS) && grp > hi_r) hi_r <= grp;
      end
      if (st_r == ST_OUT) outv_r <= 1'b1;
      else if (out_tready) outv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_valid_r <= gvalid;
      rd_col_ok_r <= 5'(col) < 5'(gma_pkg::COLS);
    end
    if (st_r == ST_RD) rd_cnt_r <= cur_cnt;
    if (st_r == ST_OUT) begin
      out_r[31:0] <= (rd_valid_r && rd_col_ok_r && rd_cnt_r != '0) ? div_mean : 32'd0;
      out_r[55:32] <= rd_valid_r ? rd_cnt_r : '0;
      out_r[64:56] <= hi_r;
      out_r[65] <= err_r;
      out_r[71:66] <= '0;
    end
  end
endmodule

// ----- design/gma_checker.sv -----
// port-level checker for the group mean accumulator, bound to the top level
`include "assert_macros.svh"
module gma_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [47:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);
  logic out_stall;
  logic clr_fire;

  assign out_stall = out_tvalid && !out_tready;
  assign clr_fire = in_tvalid && in_tready && in_tdata[1:0] == gma_pkg::ACT_CLEAR;

  `GMA_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_tvalid && $stable(out_tdata), "stall lost")
  `GMA_ASSERT(a_pad_zero, clk, rst_n, out_tvalid |-> out_tdata[71:66] == 6'd0, "output pad not zero")
  `GMA_ASSERT(a_no_in_while_out, clk, rst_n, out_tvalid |-> !in_tready, "input while pending")
  `GMA_ASSERT(a_clr_stall, clk, rst_n, clr_fire |=> !in_tready, "clear did not stall input")
  `GMA_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_tvalid, "result right after reset")
endmodule

bind group_mean_accumulator gma_checker u_gma_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);

// ----- bench/tb_group_mean_accumulator.sv -----
// testbench for group_mean_accumulator: scoreboard prediction of grouped means with directed and random traffic
class mean_scoreboard;
  logic signed [47:0] sums [0:4095];
  logic [23:0] counts [0:255];
  logic [8:0] top_group;
  logic sticky_err;
  logic [15:0] shrink;
  logic [65:0] pending [$];
  int errors;

  function void clear_state();
    foreach (sums[i]) sums[i] = '0;
    foreach (counts[i]) counts[i] = '0;
    top_group = '0;
    sticky_err = 1'b0;
  endfunction

  function logic [31:0] mean_calc(logic signed [47:0] s, logic [23:0] c);
    logic [63:0] den;
    logic [63:0] mag;
    logic [63:0] q;
    if (c == 0) return '0;
    den = {40'd0, c} * 64'd256 + {48'd0, shrink};
    mag = s[47] ? 64'(-$signed({{16{s[47]}}, s})) : {16'd0, s};
    q = (mag * 64'd256) / den;
    if (s[47]) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'(-q);
    end
    if (q > 64'h7fff_ffff) q = 64'h7fff_ffff;
    return q[31:0];
  endfunction

  function void note_input(logic [47:0] d);
    logic [1:0] act;
    logic [8:0] grp;
    logic [3:0] col;
    logic signed [31:0] val;
    logic signed [48:0] acc;
    logic ok;
    int idx;
    logic [31:0] m;
    logic [23:0] cnt;
    act = d[1:0];
    grp = d[10:2];
    col = d[14:11];
    val = d[46:15];
    ok = grp >= 1 && grp <= gma_pkg::GROUPS;
    idx = (int'(grp) - 1) * gma_pkg::COLS + int'(col);
    case (act)
      gma_pkg::ACT_CLEAR: clear_state();
      gma_pkg::ACT_ACC: begin
        if (!ok) sticky_err = 1'b1;
        else begin
          acc = 49'(sums[idx]) + 49'(val);
          if (acc > 49'sh7fff_ffff_ffff) acc = 49'sh7fff_ffff_ffff;
          if (acc < -49'sh8000_0000_0000) acc = -49'sh8000_0000_0000;
          sums[idx] = acc[47:0];
          if (col == 0 && counts[grp-1] != gma_pkg::CNT_MAX) counts[grp-1]++;
          if (grp > top_group) top_group = grp;
        end
      end
      gma_pkg::ACT_READ: begin
        m = '0;
        cnt = '0;
        if (ok) begin
          cnt = counts[grp-1];
          m = mean_calc(sums[idx], cnt);
        end
        pending.push_back({sticky_err, top_group, cnt, m});
      end
      default: ;
    endcase
  endfunction

  function bit check_result(logic [71:0] d, output logic [65:0] exp_r);
    if (pending.size() == 0) begin
      exp_r = 'x;
      return 0;
    end
    exp_r = pending.pop_front();
    return d[65:0] === exp_r && d[71:66] === 6'd0;
  endfunction
endclass

module tb_group_mean_accumulator;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;

  mean_scoreboard board;
  int cycles = 0;
  int hold_cycles = 0;
  bit stim_done = 0;
  int err_count = 0;

  group_mean_accumulator u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  task automatic report(string what, logic [71:0] got, logic [65:0] want);
    err_count++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // tvalid stays high into a back-to-back transaction and drops only for a gap
  task automatic send_item(logic [1:0] act, logic [8:0] grp, logic [3:0] col,
                           logic [31:0] val);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= {1'b0, val, col, grp, act};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_input(in_tdata);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_shrink(logic [15:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.shrink = v;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 65535) << $urandom_range(0, 16);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_phase(int n, int gmax);
    int k;
    logic [8:0] g;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 999);
      g = 9'($urandom_range(1, gmax));
      if (k < 4) send_item(gma_pkg::ACT_CLEAR, 9'd0, 4'd0, $urandom());
      else if (k < 10)
        send_item(gma_pkg::ACT_NONE, 9'($urandom()), 4'($urandom()), $urandom());
      else if (k < 25) send_item(2'($urandom_range(1, 2)), 9'($urandom_range(0, 511)),
                                 4'($urandom()), $urandom());
      else if (k < 170) send_item(gma_pkg::ACT_READ, g, 4'($urandom()), $urandom());
      else begin
        // a row of elements with column 0 first
        for (int c = 0; c < $urandom_range(1, 4); c++)
          send_item(gma_pkg::ACT_ACC, g, 4'(c), rand_value());
        i += 2;
      end
    end
  endtask

  always @(posedge clk) begin
    logic [65:0] want;
    cycles <= cycles + 1;
    if (cycles > 3_000_000) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (!board.check_result(out_tdata, want)) report("result", out_tdata, want);
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) < 70) || stim_done;
    end
  end

  initial begin
    board = new();
    board.clear_state();
    board.shrink = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    // directed part
    send_item(gma_pkg::ACT_READ, 1, 0, 0);
    send_item(gma_pkg::ACT_ACC, 1, 0, 32'h7fff_ffff);
    send_item(gma_pkg::ACT_ACC, 1, 0, 32'h7fff_ffff);
    send_item(gma_pkg::ACT_ACC, 256, 15, 32'h8000_0000);
    send_item(gma_pkg::ACT_ACC, 256, 0, 32'h0001_0000);
    send_item(gma_pkg::ACT_ACC, 3, 5, 32'h0002_0000);
    send_item(gma_pkg::ACT_ACC, 0, 0, 32'h1);
    send_item(gma_pkg::ACT_ACC, 257, 0, 32'h1);
    send_item(gma_pkg::ACT_ACC, 511, 15, 32'hffff_ffff);
    send_item(gma_pkg::ACT_NONE, 511, 15, 32'hffff_ffff);
    send_item(gma_pkg::ACT_READ, 1, 0, 0);
    send_item(gma_pkg::ACT_READ, 256, 15, 0);
    send_item(gma_pkg::ACT_READ, 3, 5, 0);
    send_item(gma_pkg::ACT_READ, 0, 0, 0);
    send_item(gma_pkg::ACT_READ, 511, 0, 0);
    send_item(gma_pkg::ACT_CLEAR, 0, 0, 0);
    send_item(gma_pkg::ACT_READ, 1, 0, 0);
    // saturate the mean: a count-free column keeps the row count at 1
    send_item(gma_pkg::ACT_ACC, 7, 0, 32'h0000_0001);
    for (int i = 0; i < 5; i++) send_item(gma_pkg::ACT_ACC, 7, 1, 32'h7fff_ffff);
    send_item(gma_pkg::ACT_READ, 7, 1, 0);
    write_shrink(16'hffff);
    send_item(gma_pkg::ACT_READ, 7, 1, 0);
    send_item(gma_pkg::ACT_READ, 7, 0, 0);
    // long receiver stall while items keep coming
    write_shrink(16'h0080);
    fork
      hold_cycles = 600;
      for (int i = 0; i < 12; i++) send_item(gma_pkg::ACT_READ, 7, 4'(i % 2), 0);
    join
    random_phase(660, 8);
    write_shrink(16'h0000);
    random_phase(660, 256);
    write_shrink(16'($urandom()));
    random_phase(660, 4);
    stim_done = 1;
    drain();
    if (err_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
